/* hw/rtl/segment_intersection_point_top_defines.svh */
// Assertion macros used by the checker of the segment intersection block.
// No dependencies; include by bare file name.
`ifndef SEGMENT_INTERSECTION_POINT_TOP_DEFINES_SVH
`define SEGMENT_INTERSECTION_POINT_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define SIP_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define SIP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/sip_pkg.sv */
// Package for the segment intersection block: widths and fixed-point format.
// No dependencies.
package sip_pkg;
  localparam int COORD_BITS = 16;  // coordinate bits used
  localparam int FRAC_BITS  = 16;  // fraction bits of the meet point
  localparam int IN_BITS    = 16;  // port width of a coordinate
  localparam int OUT_BITS   = 32;  // port width of a meet coordinate

  localparam int DFW = COORD_BITS + 1;        // coordinate difference
  localparam int PW  = 2 * DFW;               // product of two differences
  localparam int DNW = PW + 1;                // cross products, den and tn
  localparam int NW  = DFW + DNW + 1;         // numerator
  localparam int DW  = NW + FRAC_BITS;        // scaled numerator magnitude
  localparam int QB  = OUT_BITS;              // quotient bits
  localparam int RW  = ((DW > DNW + QB) ? DW : (DNW + QB)) + 1;  // remainder
  localparam int NPROD = 12;                  // products in the cross stage
endpackage

/* hw/rtl/segment_intersection_point_top.sv */
// Segment intersection test with Q16.16 meet point, fully pipelined.
// Accepts one request per cycle while the output is not stalled.
// Most of the latency is the 32-stage restoring divider, one quotient bit per stage.
// The whole pipeline advances unless a held result is stalled.
// Synchronous active-low reset clears only the stage valid bits.
// Depends on sip_pkg.
module segment_intersection_point_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [sip_pkg::IN_BITS-1:0]  in_seg_a_start_x,
  input  logic signed [sip_pkg::IN_BITS-1:0]  in_seg_a_start_y,
  input  logic signed [sip_pkg::IN_BITS-1:0]  in_seg_a_end_x,
  input  logic signed [sip_pkg::IN_BITS-1:0]  in_seg_a_end_y,
  input  logic signed [sip_pkg::IN_BITS-1:0]  in_seg_b_start_x,
  input  logic signed [sip_pkg::IN_BITS-1:0]  in_seg_b_start_y,
  input  logic signed [sip_pkg::IN_BITS-1:0]  in_seg_b_end_x,
  input  logic signed [sip_pkg::IN_BITS-1:0]  in_seg_b_end_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_intersects,
  output logic                                out_point_valid,
  output logic signed [sip_pkg::OUT_BITS-1:0] out_cross_x,
  output logic signed [sip_pkg::OUT_BITS-1:0] out_cross_y
);
  import sip_pkg::*;

  localparam int CW = COORD_BITS;

  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = out_valid && out_stall;

  // coordinates, low CW bits taken as signed
  logic signed [CW-1:0] ax0, ay0, ax1, ay1, bx0, by0, bx1, by1;
  assign ax0 = $signed(in_seg_a_start_x[CW-1:0]);
  assign ay0 = $signed(in_seg_a_start_y[CW-1:0]);
  assign ax1 = $signed(in_seg_a_end_x[CW-1:0]);
  assign ay1 = $signed(in_seg_a_end_y[CW-1:0]);
  assign bx0 = $signed(in_seg_b_start_x[CW-1:0]);
  assign by0 = $signed(in_seg_b_start_y[CW-1:0]);
  assign bx1 = $signed(in_seg_b_end_x[CW-1:0]);
  assign by1 = $signed(in_seg_b_end_y[CW-1:0]);

  function automatic logic signed [DFW-1:0] dif(logic signed [CW-1:0] a,
                                                logic signed [CW-1:0] b);
    return DFW'(a) - DFW'(b);
  endfunction

  // stage 1: differences, pairs of factors; cross = p[2k]*q[2k] - p[2k+1]*q[2k+1]
  logic signed [DFW-1:0] fa_nxt [NPROD];
  logic signed [DFW-1:0] fb_nxt [NPROD];
  logic                  box_nxt;
  always_comb begin
    // orientation of A start against B
    fa_nxt[0]  = dif(bx0, ax0); fb_nxt[0]  = dif(by1, ay0);
    fa_nxt[1]  = dif(bx1, ax0); fb_nxt[1]  = dif(by0, ay0);
    // orientation of A end against B
    fa_nxt[2]  = dif(bx0, ax1); fb_nxt[2]  = dif(by1, ay1);
    fa_nxt[3]  = dif(bx1, ax1); fb_nxt[3]  = dif(by0, ay1);
    // orientation of B start against A
    fa_nxt[4]  = dif(ax0, bx0); fb_nxt[4]  = dif(ay1, by0);
    fa_nxt[5]  = dif(ax1, bx0); fb_nxt[5]  = dif(ay0, by0);
    // orientation of B end against A
    fa_nxt[6]  = dif(ax0, bx1); fb_nxt[6]  = dif(ay1, by1);
    fa_nxt[7]  = dif(ax1, bx1); fb_nxt[7]  = dif(ay0, by1);
    // den = dx1*dy2 - dy1*dx2
    fa_nxt[8]  = dif(ax1, ax0); fb_nxt[8]  = dif(by1, by0);
    fa_nxt[9]  = dif(ay1, ay0); fb_nxt[9]  = dif(bx1, bx0);
    // tn = ex*dy2 - ey*dx2
    fa_nxt[10] = dif(bx0, ax0); fb_nxt[10] = dif(by1, by0);
    fa_nxt[11] = dif(by0, ay0); fb_nxt[11] = dif(bx1, bx0);
    // bounding box overlap
    box_nxt = ((ax0 > ax1 ? ax0 : ax1) >= (bx0 < bx1 ? bx0 : bx1)) &&
              ((ax0 < ax1 ? ax0 : ax1) <= (bx0 > bx1 ? bx0 : bx1)) &&
              ((ay0 > ay1 ? ay0 : ay1) >= (by0 < by1 ? by0 : by1)) &&
              ((ay0 < ay1 ? ay0 : ay1) <= (by0 > by1 ? by0 : by1));
  end

  logic                  v1_r;
  logic signed [DFW-1:0] fa_r [NPROD];
  logic signed [DFW-1:0] fb_r [NPROD];
  logic                  box1_r;
  logic signed [CW-1:0]  ax1c_r, ay1c_r;

  // stage 2: products
  logic                  v2_r, box2_r;
  logic signed [PW-1:0]  pr_r [NPROD];
  logic signed [CW-1:0]  ax2_r, ay2_r;
  logic signed [DFW-1:0] dx2c_r, dy2c_r;

  // stage 3: cross products, hit test
  logic signed [DNW-1:0] cr_nxt [NPROD/2];
  logic                  hit_nxt;
  always_comb begin
    for (int k = 0; k < NPROD / 2; k++) begin
      cr_nxt[k] = DNW'(pr_r[2*k]) - DNW'(pr_r[2*k+1]);
    end
    // each pair of orientations must not be strictly on the same side
    hit_nxt = box2_r &&
      !((cr_nxt[0] > 0 && cr_nxt[1] > 0) || (cr_nxt[0] < 0 && cr_nxt[1] < 0)) &&
      !((cr_nxt[2] > 0 && cr_nxt[3] > 0) || (cr_nxt[2] < 0 && cr_nxt[3] < 0));
  end

  logic                  v3_r, hit3_r;
  logic signed [DNW-1:0] den3_r, tn3_r;
  logic signed [CW-1:0]  ax3_r, ay3_r;
  logic signed [DFW-1:0] dx3_r, dy3_r;

  // stage 4: numerator products
  logic                  v4_r, hit4_r;
  logic signed [NW-1:0]  mx0_r, mx1_r, my0_r, my1_r;
  logic signed [DNW-1:0] den4_r;

  // stage 5: numerator sums
  logic                  v5_r, hit5_r, pv5_r;
  logic signed [NW-1:0]  nx5_r, ny5_r;
  logic signed [DNW-1:0] den5_r;

  // stage 6: magnitudes and overflow check, divider entry
  logic [NW-1:0]  nmx, nmy;
  logic [DNW-1:0] dmag;
  logic [RW-1:0]  dx_w, dy_w, dlim;
  always_comb begin
    nmx  = NW'(nx5_r < 0 ? -nx5_r : nx5_r);
    nmy  = NW'(ny5_r < 0 ? -ny5_r : ny5_r);
    dmag = DNW'(den5_r < 0 ? -den5_r : den5_r);
    dx_w = RW'(nmx) << FRAC_BITS;
    dy_w = RW'(nmy) << FRAC_BITS;
    dlim = RW'(dmag) << QB;
  end

  // divider pipeline, one quotient bit per stage; index 0 is the entry stage
  logic           dv_r   [QB+1];
  logic           dhit_r [QB+1];
  logic           dpv_r  [QB+1];
  logic [DNW-1:0] dden_r [QB+1];
  logic [RW-1:0]  rx_r   [QB+1];
  logic [RW-1:0]  ry_r   [QB+1];
  logic [QB-1:0]  qx_r   [QB+1];
  logic [QB-1:0]  qy_r   [QB+1];
  logic           ngx_r  [QB+1];
  logic           ngy_r  [QB+1];
  logic           ovx_r  [QB+1];
  logic           ovy_r  [QB+1];

  // output conversion: saturate, restore sign, zero when no point
  function automatic logic [OUT_BITS-1:0] fin(logic [QB-1:0] q, logic neg, logic ovf,
                                              logic pv);
    logic [QB:0] lim;
    logic [QB:0] m;
    lim = neg ? ((QB+1)'(1) << (OUT_BITS - 1)) : (((QB+1)'(1) << (OUT_BITS - 1)) - 1'b1);
    m   = (ovf || ((QB+1)'(q) > lim)) ? lim : (QB+1)'(q);
    m   = neg ? -m : m;
    return pv ? m[OUT_BITS-1:0] : '0;
  endfunction

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0; v2_r <= 1'b0; v3_r <= 1'b0; v4_r <= 1'b0; v5_r <= 1'b0;
      for (int k = 0; k <= QB; k++) dv_r[k] <= 1'b0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid; v2_r <= v1_r; v3_r <= v2_r; v4_r <= v3_r; v5_r <= v4_r;
      dv_r[0] <= v5_r;
      for (int k = 0; k < QB; k++) dv_r[k+1] <= dv_r[k];
      out_valid <= dv_r[QB];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1
      for (int k = 0; k < NPROD; k++) begin
        fa_r[k] <= fa_nxt[k];
        fb_r[k] <= fb_nxt[k];
      end
      box1_r <= box_nxt;
      ax1c_r <= ax0;
      ay1c_r <= ay0;
      // stage 2
      for (int k = 0; k < NPROD; k++) pr_r[k] <= PW'(fa_r[k]) * PW'(fb_r[k]);
      box2_r <= box1_r;
      ax2_r  <= ax1c_r;
      ay2_r  <= ay1c_r;
      dx2c_r <= fa_r[8];
      dy2c_r <= fa_r[9];
      // stage 3
      hit3_r <= hit_nxt;
      den3_r <= cr_nxt[4];
      tn3_r  <= cr_nxt[5];
      ax3_r  <= ax2_r;
      ay3_r  <= ay2_r;
      dx3_r  <= dx2c_r;
      dy3_r  <= dy2c_r;
      // stage 4
      hit4_r <= hit3_r;
      mx0_r  <= NW'(ax3_r) * NW'(den3_r);
      mx1_r  <= NW'(dx3_r) * NW'(tn3_r);
      my0_r  <= NW'(ay3_r) * NW'(den3_r);
      my1_r  <= NW'(dy3_r) * NW'(tn3_r);
      den4_r <= den3_r;
      // stage 5
      hit5_r <= hit4_r;
      pv5_r  <= hit4_r && (den4_r != 0);
      nx5_r  <= mx0_r + mx1_r;
      ny5_r  <= my0_r + my1_r;
      den5_r <= den4_r;
      // stage 6: divider entry
      dhit_r[0] <= hit5_r;
      dpv_r[0]  <= pv5_r;
      dden_r[0] <= dmag;
      rx_r[0]   <= dx_w;
      ry_r[0]   <= dy_w;
      qx_r[0]   <= '0;
      qy_r[0]   <= '0;
      ngx_r[0]  <= (nx5_r < 0) ^ (den5_r < 0);
      ngy_r[0]  <= (ny5_r < 0) ^ (den5_r < 0);
      ovx_r[0]  <= dx_w >= dlim;
      ovy_r[0]  <= dy_w >= dlim;
      // restoring division stages, quotient bit QB-1-k at stage k
      for (int k = 0; k < QB; k++) begin
        dhit_r[k+1] <= dhit_r[k];
        dpv_r[k+1]  <= dpv_r[k];
        dden_r[k+1] <= dden_r[k];
        ngx_r[k+1]  <= ngx_r[k];
        ngy_r[k+1]  <= ngy_r[k];
        ovx_r[k+1]  <= ovx_r[k];
        ovy_r[k+1]  <= ovy_r[k];
        if (rx_r[k] >= (RW'(dden_r[k]) << (QB - 1 - k))) begin
          rx_r[k+1] <= rx_r[k] - (RW'(dden_r[k]) << (QB - 1 - k));
          qx_r[k+1] <= qx_r[k] | (QB'(1) << (QB - 1 - k));
        end else begin
          rx_r[k+1] <= rx_r[k];
          qx_r[k+1] <= qx_r[k];
        end
        if (ry_r[k] >= (RW'(dden_r[k]) << (QB - 1 - k))) begin
          ry_r[k+1] <= ry_r[k] - (RW'(dden_r[k]) << (QB - 1 - k));
          qy_r[k+1] <= qy_r[k] | (QB'(1) << (QB - 1 - k));
        end else begin
          ry_r[k+1] <= ry_r[k];
          qy_r[k+1] <= qy_r[k];
        end
      end
      // output register
      out_intersects  <= dhit_r[QB];
      out_point_valid <= dpv_r[QB];
      out_cross_x     <= fin(qx_r[QB], ngx_r[QB], ovx_r[QB], dpv_r[QB]);
      out_cross_y     <= fin(qy_r[QB], ngy_r[QB], ovy_r[QB], dpv_r[QB]);
    end
  end

endmodule

/* hw/rtl/sip_checker.sv */
// Port-level checker for segment_intersection_point_top, bound to the top level.
// Depends on sip_pkg and segment_intersection_point_top_defines.svh.
`include "segment_intersection_point_top_defines.svh"

module sip_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_stall,
  input logic                                out_valid,
  input logic                                out_stall,
  input logic                                out_intersects,
  input logic                                out_point_valid,
  input logic signed [sip_pkg::OUT_BITS-1:0] out_cross_x,
  input logic signed [sip_pkg::OUT_BITS-1:0] out_cross_y
);
  import sip_pkg::*;

  // a unique point implies the segments touch
  `SIP_ASSERT_NOW(a_pv_hit, clk, rst_n, out_valid && out_point_valid, out_intersects, "point without touch")
  // no point means zero coordinates
  `SIP_ASSERT_NOW(a_zero, clk, rst_n, out_valid && !out_point_valid, (out_cross_x == 0) && (out_cross_y == 0), "nonzero point when invalid")
  // input is held back only behind a stalled result
  `SIP_ASSERT_NOW(a_in_stall, clk, rst_n, in_stall, out_valid && out_stall, "input stalled without output stall")
  // a stalled result request holds
  `SIP_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_cross_x) && $stable(out_cross_y), "stalled result changed")
endmodule

bind segment_intersection_point_top sip_checker u_sip_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_intersects (out_intersects),
  .out_point_valid(out_point_valid),
  .out_cross_x    (out_cross_x),
  .out_cross_y    (out_cross_y)
);
